// File: rtl/vtpr_pkg.sv
// Package for the virtual texture page residency manager.
// Holds pool geometry, field widths, codes and the state machine type.
// No dependencies.
package vtpr_pkg;

   localparam int POOL_COLS    = 16;
   localparam int POOL_ROWS    = 16;
   localparam int TILE_COUNT   = POOL_COLS * POOL_ROWS;
   localparam int MAX_TEXTURES = 256;

   localparam int TILE_AW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
   localparam int TEX_AW  = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;

   localparam int FRAME_W  = 32;
   localparam int STREAM_W = 8;
   localparam int RES_W    = 9;
   localparam int FLOOR_W  = 4;

   localparam logic [STREAM_W-1:0] MAX_STREAMS_RESET = 8'd16;

   typedef struct packed {
      logic [7:0] tex;
      logic [3:0] mip;
      logic [5:0] row;
      logic [5:0] col;
   } vtpr_key_type;

   localparam int KEY_W   = $bits(vtpr_key_type);
   localparam int ENTRY_W = KEY_W + FRAME_W;

   typedef enum logic [1:0] {
      KIND_FRAME   = 2'd0,
      KIND_REQUEST = 2'd1,
      KIND_TEXTURE = 2'd2
   } vtpr_kind_type;

   typedef enum logic [2:0] {
      OUT_DONE       = 3'd0,
      OUT_IGNORED    = 3'd1,
      OUT_HIT        = 3'd2,
      OUT_LOAD_FREE  = 3'd3,
      OUT_LOAD_EVICT = 3'd4,
      OUT_BUDGET     = 3'd5,
      OUT_SATURATED  = 3'd6
   } vtpr_outcome_type;

   localparam logic [0:0] CSR_RESERVED_TILES = 1'b0;
   localparam logic [0:0] CSR_MAX_STREAMS    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEX_CHECK,
      ST_SCAN,
      ST_DECIDE,
      ST_DELIVER
   } vtpr_state_type;

endpackage

// File: rtl/vtpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module vtpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/virtual_texture_page_residency_lru_top.sv
// Frame and texture transactions go from ST_IDLE to ST_DELIVER and a registered response;
// page requests pass ST_TEX_CHECK, then ST_SCAN and ST_DECIDE unless ignored. One transaction
// at a time; a scanned request holds the block for one tile read per pool tile plus decision.
// Reset (synchronous, active high) clears valid bits, counters and control state at once (no
// clearing pass), loads CSR defaults, leaves payload unreset. Depends on vtpr_pkg, vtpr_ram.
module virtual_texture_page_residency_lru_top (
   input  logic        clock,
   input  logic        reset,
   // csr
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // tex[7:0] mip[11:8] col[17:12] row[23:18] floor_mip[27:24] texture_valid[28]
   input  logic [31:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tile[7:0] evicted[8] ev_tex[16:9] ev_mip[20:17] ev_col[26:21] ev_row[32:27]
   output logic [39:0] rsp_tdata,
   // outcome[2:0]
   output logic [2:0]  rsp_tuser
);

   localparam int TAW = vtpr_pkg::TILE_AW;
   localparam int XAW = vtpr_pkg::TEX_AW;

   vtpr_pkg::vtpr_state_type state_ff, state_in;

   logic [vtpr_pkg::RES_W-1:0]    reserved_ff;
   logic [vtpr_pkg::STREAM_W-1:0] max_streams_ff;
   logic [vtpr_pkg::FRAME_W-1:0]  frame_ff, frame_in;
   logic [vtpr_pkg::STREAM_W-1:0] streams_ff, streams_in;
   logic [vtpr_pkg::RES_W-1:0]    next_free_ff, next_free_in;

   logic [vtpr_pkg::MAX_TEXTURES-1:0] tex_valid_ff, tex_valid_in;
   logic [vtpr_pkg::TILE_COUNT-1:0]   tile_valid_ff, tile_valid_in;

   vtpr_pkg::vtpr_key_type key_ff, key_in;

   logic [TAW:0]   scan_addr_ff, scan_addr_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [TAW-1:0] rd_idx_ff, rd_idx_in;

   logic                          hit_found_ff, hit_found_in;
   logic [TAW-1:0]                hit_idx_ff, hit_idx_in;
   logic                          vic_found_ff, vic_found_in;
   logic [TAW-1:0]                vic_idx_ff, vic_idx_in;
   logic [vtpr_pkg::FRAME_W-1:0]  vic_frame_ff, vic_frame_in;
   vtpr_pkg::vtpr_key_type        vic_key_ff, vic_key_in;

   vtpr_pkg::vtpr_outcome_type res_outcome_ff, res_outcome_in;
   logic [7:0]                 res_tile_ff, res_tile_in;
   logic                       res_evicted_ff, res_evicted_in;
   vtpr_pkg::vtpr_key_type     res_evkey_ff, res_evkey_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_tuser_ff, rsp_tuser_in;
   logic [39:0] rsp_tdata_ff, rsp_tdata_in;

   // input fields
   logic [7:0] in_tex;
   logic [3:0] in_mip;
   logic [5:0] in_col;
   logic [5:0] in_row;
   logic [3:0] in_floor;
   logic       in_tvalid;
   logic       req_accept;
   logic       in_tex_oob;

   assign in_tex     = req_tdata[7:0];
   assign in_mip     = req_tdata[11:8];
   assign in_col     = req_tdata[17:12];
   assign in_row     = req_tdata[23:18];
   assign in_floor   = req_tdata[27:24];
   assign in_tvalid  = req_tdata[28];
   assign req_tready = (state_ff == vtpr_pkg::ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign in_tex_oob = ({1'b0, in_tex} >= 9'(vtpr_pkg::MAX_TEXTURES));

   // texture floor memory
   logic                        tex_we;
   logic [vtpr_pkg::FLOOR_W-1:0] tex_floor;

   assign tex_we = req_accept && (req_tuser == vtpr_pkg::KIND_TEXTURE) && !in_tex_oob;

   vtpr_ram #(
      .WIDTH (vtpr_pkg::FLOOR_W),
      .DEPTH (vtpr_pkg::MAX_TEXTURES)
   ) u_tex_ram (
      .clock (clock),
      .we    (tex_we),
      .waddr (in_tex[XAW-1:0]),
      .wdata (in_floor),
      .raddr (in_tex[XAW-1:0]),
      .rdata (tex_floor)
   );

   // tile memory: page key and frame of last touch
   logic                          tile_we;
   logic [TAW-1:0]                tile_waddr;
   logic [vtpr_pkg::ENTRY_W-1:0]  tile_rdata;
   vtpr_pkg::vtpr_key_type        rd_key;
   logic [vtpr_pkg::FRAME_W-1:0]  rd_frame;

   assign rd_key   = vtpr_pkg::vtpr_key_type'(tile_rdata[vtpr_pkg::ENTRY_W-1:vtpr_pkg::FRAME_W]);
   assign rd_frame = tile_rdata[vtpr_pkg::FRAME_W-1:0];

   vtpr_ram #(
      .WIDTH (vtpr_pkg::ENTRY_W),
      .DEPTH (vtpr_pkg::TILE_COUNT)
   ) u_tile_ram (
      .clock (clock),
      .we    (tile_we),
      .waddr (tile_waddr),
      .wdata ({key_ff, frame_ff}),
      .raddr (scan_addr_ff[TAW-1:0]),
      .rdata (tile_rdata)
   );

   // decision terms
   logic                 tex_ignore;
   logic                 scan_done;
   logic                 out_free;
   logic [vtpr_pkg::RES_W:0] free_sum;
   logic                 free_ok;

   assign tex_ignore = ({1'b0, key_ff.tex} >= 9'(vtpr_pkg::MAX_TEXTURES))
                       || !tex_valid_ff[key_ff.tex[XAW-1:0]]
                       || (key_ff.mip >= tex_floor);
   assign scan_done  = scan_addr_ff[TAW] && !rd_vld_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign free_sum   = {1'b0, reserved_ff} + {1'b0, next_free_ff};
   assign free_ok    = (free_sum < (vtpr_pkg::RES_W + 1)'(vtpr_pkg::TILE_COUNT));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vtpr_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == vtpr_pkg::KIND_REQUEST) begin
                  state_in = vtpr_pkg::ST_TEX_CHECK;
               end else begin
                  state_in = vtpr_pkg::ST_DELIVER;
               end
            end
         end
         vtpr_pkg::ST_TEX_CHECK: begin
            state_in = tex_ignore ? vtpr_pkg::ST_DELIVER : vtpr_pkg::ST_SCAN;
         end
         vtpr_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = vtpr_pkg::ST_DECIDE;
            end
         end
         vtpr_pkg::ST_DECIDE: begin
            state_in = vtpr_pkg::ST_DELIVER;
         end
         vtpr_pkg::ST_DELIVER: begin
            if (out_free) begin
               state_in = vtpr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vtpr_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      frame_in       = frame_ff;
      streams_in     = streams_ff;
      next_free_in   = next_free_ff;
      tex_valid_in   = tex_valid_ff;
      tile_valid_in  = tile_valid_ff;
      key_in         = key_ff;
      scan_addr_in   = scan_addr_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      vic_found_in   = vic_found_ff;
      vic_idx_in     = vic_idx_ff;
      vic_frame_in   = vic_frame_ff;
      vic_key_in     = vic_key_ff;
      res_outcome_in = res_outcome_ff;
      res_tile_in    = res_tile_ff;
      res_evicted_in = res_evicted_ff;
      res_evkey_in   = res_evkey_ff;
      tile_we        = 1'b0;
      tile_waddr     = hit_idx_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_tuser_in   = rsp_tuser_ff;
      rsp_tdata_in   = rsp_tdata_ff;

      unique case (state_ff)
         vtpr_pkg::ST_IDLE: begin
            if (req_accept) begin
               res_tile_in    = '0;
               res_evicted_in = 1'b0;
               res_evkey_in   = '0;
               res_outcome_in = vtpr_pkg::OUT_IGNORED;
               key_in         = '{tex: in_tex, mip: in_mip, row: in_row, col: in_col};
               unique case (req_tuser)
                  vtpr_pkg::KIND_FRAME: begin
                     frame_in       = frame_ff + 1'b1;
                     streams_in     = '0;
                     res_outcome_in = vtpr_pkg::OUT_DONE;
                  end
                  vtpr_pkg::KIND_TEXTURE: begin
                     if (!in_tex_oob) begin
                        tex_valid_in[in_tex[XAW-1:0]] = in_tvalid;
                        res_outcome_in = vtpr_pkg::OUT_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         vtpr_pkg::ST_TEX_CHECK: begin
            scan_addr_in = '0;
            hit_found_in = 1'b0;
            vic_found_in = 1'b0;
         end
         vtpr_pkg::ST_SCAN: begin
            if (!scan_addr_ff[TAW]) begin
               rd_vld_in    = 1'b1;
               rd_idx_in    = scan_addr_ff[TAW-1:0];
               scan_addr_in = scan_addr_ff + 1'b1;
            end
            if (rd_vld_ff && tile_valid_ff[rd_idx_ff]) begin
               if (rd_key == key_ff && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = rd_idx_ff;
               end
               if (rd_frame < frame_ff && (!vic_found_ff || rd_frame < vic_frame_ff)) begin
                  vic_found_in = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_frame_in = rd_frame;
                  vic_key_in   = rd_key;
               end
            end
         end
         vtpr_pkg::ST_DECIDE: begin
            priority if (hit_found_ff) begin
               res_outcome_in = vtpr_pkg::OUT_HIT;
               res_tile_in    = 8'(hit_idx_ff);
               tile_we        = 1'b1;
               tile_waddr     = hit_idx_ff;
            end else if (streams_ff >= max_streams_ff) begin
               res_outcome_in = vtpr_pkg::OUT_BUDGET;
            end else if (free_ok) begin
               res_outcome_in = vtpr_pkg::OUT_LOAD_FREE;
               res_tile_in    = 8'(free_sum[TAW-1:0]);
               tile_we        = 1'b1;
               tile_waddr     = free_sum[TAW-1:0];
               next_free_in   = next_free_ff + 1'b1;
               streams_in     = streams_ff + 1'b1;
            end else if (vic_found_ff) begin
               res_outcome_in = vtpr_pkg::OUT_LOAD_EVICT;
               res_tile_in    = 8'(vic_idx_ff);
               res_evicted_in = 1'b1;
               res_evkey_in   = vic_key_ff;
               tile_we        = 1'b1;
               tile_waddr     = vic_idx_ff;
               streams_in     = streams_ff + 1'b1;
            end else begin
               res_outcome_in = vtpr_pkg::OUT_SATURATED;
            end
            if (tile_we) begin
               tile_valid_in[tile_waddr] = 1'b1;
            end
         end
         vtpr_pkg::ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tuser_in = res_outcome_ff;
               rsp_tdata_in = {7'd0, res_evkey_ff.row, res_evkey_ff.col, res_evkey_ff.mip,
                               res_evkey_ff.tex, res_evicted_ff, res_tile_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff    <= '0;
         max_streams_ff <= vtpr_pkg::MAX_STREAMS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            vtpr_pkg::CSR_RESERVED_TILES: reserved_ff    <= csr_data;
            vtpr_pkg::CSR_MAX_STREAMS:    max_streams_ff <= csr_data[vtpr_pkg::STREAM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vtpr_pkg::ST_IDLE;
         frame_ff      <= '0;
         streams_ff    <= '0;
         next_free_ff  <= '0;
         tex_valid_ff  <= '0;
         tile_valid_ff <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_ff      <= frame_in;
         streams_ff    <= streams_in;
         next_free_ff  <= next_free_in;
         tex_valid_ff  <= tex_valid_in;
         tile_valid_ff <= tile_valid_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      scan_addr_ff   <= scan_addr_in;
      rd_idx_ff      <= rd_idx_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      vic_found_ff   <= vic_found_in;
      vic_idx_ff     <= vic_idx_in;
      vic_frame_ff   <= vic_frame_in;
      vic_key_ff     <= vic_key_in;
      res_outcome_ff <= res_outcome_in;
      res_tile_ff    <= res_tile_in;
      res_evicted_ff <= res_evicted_in;
      res_evkey_ff   <= res_evkey_in;
      rsp_tuser_ff   <= rsp_tuser_in;
      rsp_tdata_ff   <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: rtl/vtpr_checker.sv
// Port-level checks for the virtual texture page residency manager.
// Bound to virtual_texture_page_residency_lru_top; depends on vtpr_pkg.
module vtpr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_evict_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[8] == (rsp_tuser == vtpr_pkg::OUT_LOAD_EVICT)))
      else $error("evicted flag disagrees with outcome");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != vtpr_pkg::OUT_LOAD_EVICT |-> rsp_tdata[32:9] == '0)
      else $error("evicted page fields set without eviction");

   a_frame_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == vtpr_pkg::KIND_FRAME && !rsp_tvalid
      |=> !req_tready ##1 (rsp_tvalid && rsp_tuser == vtpr_pkg::OUT_DONE))
      else $error("frame transaction response missing");

endmodule

bind virtual_texture_page_residency_lru_top vtpr_checker u_vtpr_checker (.*);
